### rtl/abic_pkg.sv
// Shared types and constants for the body integrate and collide block.
package abic_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY  = 3'd0,
        REG_FRICTION = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_OFFSET_Y = 3'd3,
        REG_OFFSET_Z = 3'd4,
        REG_HALF_X   = 3'd5,
        REG_HALF_Y   = 3'd6,
        REG_HALF_Z   = 3'd7
    } cfg_idx_t;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_COLLIDE = 1'b1;

    localparam logic [23:0] GRAVITY_RST = 24'd642908;
    localparam logic [30:0] HALF_RST    = 31'd65536;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = -32'sh7FFF_FFFF - 32'sd1;

    // Clamp a 50-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 50'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/abic_mac.sv
// Shared multiply-shift-accumulate unit: sat(base + (a*b >>> sh)), optional negate.
module abic_mac (
    input  logic                aclk,
    input  logic                start,
    input  logic signed [31:0]  op_a,
    input  logic signed [24:0]  op_b,
    input  logic                shift8,
    input  logic                negate,
    input  logic signed [31:0]  base,
    output logic signed [31:0]  result
);
    import abic_pkg::*;

    logic signed [56:0] prod_reg;
    logic               shift8_reg;
    logic               negate_reg;
    logic signed [31:0] base_reg;
    logic signed [49:0] shifted;
    logic signed [49:0] sum;

    // The product is registered; the shift, add and clamp follow next cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg   <= 57'(op_a) * 57'(op_b);
            shift8_reg <= shift8;
            negate_reg <= negate;
            base_reg   <= base;
        end
    end

    always_comb begin
        if (shift8_reg) begin
            shifted = 50'(prod_reg >>> 8);
        end else begin
            shifted = 50'(prod_reg >>> 16);
        end
        if (negate_reg) begin
            sum = 50'(base_reg) - shifted;
        end else begin
            sum = 50'(base_reg) + shifted;
        end
        result = sat32(sum);
    end

endmodule

### rtl/aabb_body_integrate_collide_unit.sv
// Top level: one rigid body with tick integration and box collision.
// A tick runs ten operations, each through the MUL and ACC states of the one shared
// multiply-accumulate unit. A collide passes through the COL_A and COL_B states.
// One item at a time; the next is accepted once the result word is taken.
// Synchronous active-low reset clears body state and restores register defaults.
module aabb_body_integrate_collide_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // step_time[15:0], obstacle_x[47:16], obstacle_y[79:48], obstacle_z[111:80],
    // obstacle_half_x[142:112], obstacle_half_y[173:143], obstacle_half_z[204:174]
    input  logic [207:0] s_tdata,
    input  logic         s_tuser,     // func
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x/y/z [95:0], new_vel_x/y/z [191:96], contacts[197:192]
    output logic [199:0] m_tdata,
    output logic         m_tuser      // hit
);
    import abic_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_COL_A, ST_COL_B, ST_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] op_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] fr_reg [3];
    logic [5:0]  flags_reg;
    logic        hit_reg;
    logic [23:0] gravity_reg;
    logic [15:0] friction_reg;
    logic signed [31:0] offset_reg [3];
    logic [30:0] half_reg [3];
    logic [15:0] dt_reg;
    logic signed [31:0] ob_reg [3];
    logic [30:0] obh_reg [3];
    logic signed [34:0] pen_reg [3];
    logic        ovl_reg [3];
    logic        below_reg [3];

    logic               mac_start;
    logic signed [31:0] mac_a;
    logic signed [24:0] mac_b;
    logic               mac_sh8;
    logic               mac_neg;
    logic signed [31:0] mac_base;
    logic signed [31:0] mac_res;

    abic_mac u_mac (
        .aclk(aclk), .start(mac_start), .op_a(mac_a), .op_b(mac_b),
        .shift8(mac_sh8), .negate(mac_neg), .base(mac_base), .result(mac_res)
    );

    // Tick operation order: friction x,y,z; gravity; velocity x,y,z; position x,y,z.
    logic [1:0] ax;
    always_comb begin
        mac_start = (state_reg == ST_MUL);
        mac_a = '0;
        mac_b = '0;
        mac_sh8 = 1'b0;
        mac_neg = 1'b0;
        mac_base = '0;
        ax = 2'd0;
        if (op_reg < 4'd3) begin
            ax = op_reg[1:0];
            mac_a = vel_reg[ax];
            mac_b = 25'(friction_reg);
            mac_sh8 = 1'b1;
            mac_neg = 1'b1;
        end else if (op_reg == 4'd3) begin
            mac_a = 32'(gravity_reg);
            mac_b = 25'(dt_reg);
            mac_neg = 1'b1;
            mac_base = vel_reg[1];
        end else if (op_reg < 4'd7) begin
            ax = 2'(op_reg - 4'd4);
            mac_a = fr_reg[ax];
            mac_b = 25'(dt_reg);
            mac_base = vel_reg[ax];
        end else begin
            ax = 2'(op_reg - 4'd7);
            mac_a = vel_reg[ax];
            mac_b = 25'(dt_reg);
            mac_base = pos_reg[ax];
        end
    end

    // Collide arithmetic on registered operands: edges and penetrations are combinational, captured in ST_COL_A.
    logic signed [34:0] ca [3];
    logic signed [34:0] p1 [3];
    logic signed [34:0] p2 [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ca[i] = 35'(pos_reg[i]) + 35'(offset_reg[i]);
            p1[i] = ca[i] + 35'(half_reg[i]) - 35'(ob_reg[i]) + 35'(obh_reg[i]);
            p2[i] = 35'(ob_reg[i]) + 35'(obh_reg[i]) - ca[i] + 35'(half_reg[i]);
        end
    end

    logic [1:0] sel_ax;
    logic signed [49:0] push;
    always_comb begin
        if (pen_reg[0] < pen_reg[1] && pen_reg[0] < pen_reg[2]) begin
            sel_ax = 2'd0;
        end else if (pen_reg[1] < pen_reg[0] && pen_reg[1] < pen_reg[2]) begin
            sel_ax = 2'd1;
        end else begin
            sel_ax = 2'd2;
        end
        if (below_reg[sel_ax]) begin
            push = 50'(pos_reg[sel_ax]) - 50'(pen_reg[sel_ax]);
        end else begin
            push = 50'(pos_reg[sel_ax]) + 50'(pen_reg[sel_ax]);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {2'b00, flags_reg, vel_reg[2], vel_reg[1], vel_reg[0],
                        pos_reg[2], pos_reg[1], pos_reg[0]};
    assign m_tuser   = hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= '0;
            gravity_reg  <= GRAVITY_RST;
            friction_reg <= '0;
            flags_reg    <= '0;
            hit_reg      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]    <= '0;
                vel_reg[i]    <= '0;
                offset_reg[i] <= '0;
                half_reg[i]   <= HALF_RST;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_GRAVITY:  gravity_reg   <= cfg_data[23:0];
                    REG_FRICTION: friction_reg  <= cfg_data[15:0];
                    REG_OFFSET_X: offset_reg[0] <= cfg_data;
                    REG_OFFSET_Y: offset_reg[1] <= cfg_data;
                    REG_OFFSET_Z: offset_reg[2] <= cfg_data;
                    REG_HALF_X:   half_reg[0]   <= cfg_data[30:0];
                    REG_HALF_Y:   half_reg[1]   <= cfg_data[30:0];
                    REG_HALF_Z:   half_reg[2]   <= cfg_data[30:0];
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        dt_reg     <= s_tdata[15:0];
                        ob_reg[0]  <= s_tdata[47:16];
                        ob_reg[1]  <= s_tdata[79:48];
                        ob_reg[2]  <= s_tdata[111:80];
                        obh_reg[0] <= s_tdata[142:112];
                        obh_reg[1] <= s_tdata[173:143];
                        obh_reg[2] <= s_tdata[204:174];
                        op_reg     <= '0;
                        hit_reg    <= 1'b0;
                        if (s_tuser == FUNC_TICK) begin
                            state_reg <= ST_MUL;
                        end else begin
                            state_reg <= ST_COL_A;
                        end
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC: begin
                    if (op_reg < 4'd3) begin
                        // Vertical friction only acts while resting on the ground.
                        if (op_reg == 4'd1 && !flags_reg[0]) begin
                            fr_reg[1] <= '0;
                        end else begin
                            fr_reg[ax] <= mac_res;
                        end
                    end else if (op_reg == 4'd3) begin
                        vel_reg[1] <= mac_res;
                    end else if (op_reg < 4'd7) begin
                        vel_reg[ax] <= mac_res;
                    end else begin
                        pos_reg[ax] <= mac_res;
                    end
                    if (op_reg == 4'd9) begin
                        flags_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        op_reg    <= op_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_COL_A: begin
                    for (int i = 0; i < 3; i++) begin
                        ovl_reg[i]   <= (p1[i] >= 35'sd0) && (p2[i] >= 35'sd0);
                        pen_reg[i]   <= (p1[i] < p2[i]) ? p1[i] : p2[i];
                        below_reg[i] <= ca[i] < 35'(ob_reg[i]);
                    end
                    state_reg <= ST_COL_B;
                end
                ST_COL_B: begin
                    if (ovl_reg[0] && ovl_reg[1] && ovl_reg[2]) begin
                        hit_reg <= 1'b1;
                        pos_reg[sel_ax] <= sat32(push);
                        unique case (sel_ax)
                            2'd0: flags_reg[below_reg[0] ? 3 : 2] <= 1'b1;
                            2'd1: begin
                                if (below_reg[1]) begin
                                    flags_reg[1] <= 1'b1;
                                    vel_reg[1]   <= '0;
                                end else begin
                                    flags_reg[0] <= 1'b1;
                                    if (vel_reg[1] < 0) vel_reg[1] <= '0;
                                end
                            end
                            default: flags_reg[below_reg[2] ? 4 : 5] <= 1'b1;
                        endcase
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
